>>> design/bdb_pkg.sv
package bdb_pkg;

   localparam int SAMPLE_BITS       = 32;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int CFG_BITS          = 24;
   localparam int CSR_INDEX_BITS    = 4;
   localparam int COUNT_BITS        = 2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CFG_BITS-1:0]       cfg_word_type;
   typedef logic [COUNT_BITS-1:0]     count_type;

   localparam csr_index_type CSR_MIN_BLINK_US = 4'd0;
   localparam csr_index_type CSR_MAX_BLINK_US = 4'd1;
   localparam csr_index_type CSR_MIN_GAP_US   = 4'd2;
   localparam csr_index_type CSR_MAX_GAP_US   = 4'd3;

   localparam cfg_word_type MIN_BLINK_US_RESET = 24'd50000;
   localparam cfg_word_type MAX_BLINK_US_RESET = 24'd250000;
   localparam cfg_word_type MIN_GAP_US_RESET   = 24'd50000;
   localparam cfg_word_type MAX_GAP_US_RESET   = 24'd500000;

   // second blink in a row is the double
   localparam count_type DOUBLE_COUNT = 2'd2;

   typedef struct packed {
      cfg_word_type min_blink_us;
      cfg_word_type max_blink_us;
      cfg_word_type min_gap_us;
      cfg_word_type max_gap_us;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_time_us;
      logic                   eye_closed;
      logic                   fixating;
   } item_type;

   typedef struct packed {
      logic blink;
      logic second_blink;
   } result_type;

endpackage

>>> design/bdb_ifs.sv
interface bdb_req_if;
   logic                             valid;
   logic                             ready;
   logic [bdb_pkg::SAMPLE_BITS-1:0]  sample_time_us;
   logic                             eye_closed;
   logic                             fixating;

   modport source (output valid, output sample_time_us, output eye_closed, output fixating,
                   input ready);
   modport sink   (input valid, input sample_time_us, input eye_closed, input fixating,
                   output ready);
endinterface

interface bdb_rsp_if;
   logic valid;
   logic ready;
   logic blink;
   logic second_blink;

   modport source (output valid, output blink, output second_blink, input ready);
   modport sink   (input valid, input blink, input second_blink, output ready);
endinterface

interface bdb_csr_if;
   logic                     valid;
   logic                     ready;
   bdb_pkg::csr_index_type   index;
   bdb_pkg::cfg_word_type    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/bdb_csr.sv
module bdb_csr (
   input  logic             clock,
   input  logic             reset,
   bdb_csr_if.sink          csr_ch,
   output bdb_pkg::cfg_type cfg
);

   bdb_pkg::cfg_type cfg_ff;
   bdb_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            bdb_pkg::CSR_MIN_BLINK_US: cfg_in.min_blink_us = csr_ch.data;
            bdb_pkg::CSR_MAX_BLINK_US: cfg_in.max_blink_us = csr_ch.data;
            bdb_pkg::CSR_MIN_GAP_US:   cfg_in.min_gap_us   = csr_ch.data;
            bdb_pkg::CSR_MAX_GAP_US:   cfg_in.max_gap_us   = csr_ch.data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_blink_us <= bdb_pkg::MIN_BLINK_US_RESET;
         cfg_ff.max_blink_us <= bdb_pkg::MAX_BLINK_US_RESET;
         cfg_ff.min_gap_us   <= bdb_pkg::MIN_GAP_US_RESET;
         cfg_ff.max_gap_us   <= bdb_pkg::MAX_GAP_US_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/bdb_classify.sv
module bdb_classify #(
   parameter int TIME_BITS = bdb_pkg::TIME_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  bdb_pkg::item_type   item,
   input  bdb_pkg::cfg_type    cfg,
   output bdb_pkg::result_type result
);

   localparam int EXT_BITS = (TIME_BITS > bdb_pkg::SAMPLE_BITS) ? TIME_BITS
                                                                : bdb_pkg::SAMPLE_BITS;
   localparam int CMP_BITS = (TIME_BITS > bdb_pkg::CFG_BITS) ? TIME_BITS : bdb_pkg::CFG_BITS;

   logic                    prev_closed_ff, prev_closed_in;
   bdb_pkg::count_type      count_ff, count_in;
   logic [TIME_BITS-1:0]    close_time_ff, close_time_in;
   logic [TIME_BITS-1:0]    reopen_time_ff, reopen_time_in;

   logic [EXT_BITS-1:0]     t_ext;
   logic [TIME_BITS-1:0]    t;
   logic [TIME_BITS-1:0]    gap_raw;
   logic [TIME_BITS-1:0]    dur_raw;
   logic [CMP_BITS-1:0]     gap;
   logic [CMP_BITS-1:0]     dur;
   logic                    gap_bad;
   logic                    dur_good;
   bdb_pkg::count_type      count_inc;

   // timestamp is truncated or zero-extended to the internal time width
   assign t_ext = EXT_BITS'(item.sample_time_us);
   assign t     = t_ext[TIME_BITS-1:0];

   // differences wrap at the time width before they are widened for the compares
   assign gap_raw = t - reopen_time_ff;
   assign dur_raw = t - close_time_ff;
   assign gap     = CMP_BITS'(gap_raw);
   assign dur     = CMP_BITS'(dur_raw);

   assign gap_bad  = (gap < CMP_BITS'(cfg.min_gap_us)) || (gap > CMP_BITS'(cfg.max_gap_us));
   assign dur_good = (dur > CMP_BITS'(cfg.min_blink_us)) && (dur < CMP_BITS'(cfg.max_blink_us));
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      prev_closed_in      = prev_closed_ff;
      count_in            = count_ff;
      close_time_in       = close_time_ff;
      reopen_time_in      = reopen_time_ff;
      result.blink        = 1'b0;
      result.second_blink = 1'b0;
      if (item.fixating) begin
         prev_closed_in = item.eye_closed;
         if (item.eye_closed && !prev_closed_ff) begin
            close_time_in = t;
            if (gap_bad) begin
               count_in = '0;
            end
         end else if (!item.eye_closed && prev_closed_ff) begin
            reopen_time_in = t;
            if (dur_good) begin
               result.blink = 1'b1;
               if (count_inc == bdb_pkg::DOUBLE_COUNT) begin
                  result.second_blink = 1'b1;
                  count_in            = '0;
               end else begin
                  count_in = count_inc;
               end
            end else begin
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_closed_ff <= 1'b0;
         count_ff       <= '0;
         close_time_ff  <= '0;
         reopen_time_ff <= '0;
      end else if (step) begin
         prev_closed_ff <= prev_closed_in;
         count_ff       <= count_in;
         close_time_ff  <= close_time_in;
         reopen_time_ff <= reopen_time_in;
      end
   end

endmodule

>>> design/blink_double_blink_classifier_top.sv
// Blink and double-blink classifier. Each request is one eye sample (timestamp in
// microseconds, eye-closed flag, fixating gate) and gives exactly one response with the
// blink and second_blink flags. A request is taken into an input register, classified
// combinationally against the stored close/reopen times and blink count, and the
// response is held in an output register. One request is taken every cycle while the
// response side is not stalled. Req ready follows rsp ready combinationally when both
// registers are full. The four threshold registers (min/max blink, min/max gap, 24
// bits, indices 0 to 3) are written through the csr channel, which is always ready;
// writes to other indices are ignored.
module blink_double_blink_classifier_top #(
   parameter int TIME_BITS = bdb_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bdb_req_if.sink     req_ch,
   bdb_rsp_if.source   rsp_ch,
   bdb_csr_if.sink     csr_ch
);

   bdb_pkg::cfg_type    cfg;
   bdb_pkg::item_type   req_item_ff;
   bdb_pkg::result_type rsp_result_ff;
   bdb_pkg::result_type result;
   logic                req_valid_ff, req_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance;
   logic                step;
   logic                req_take;

   assign advance     = !rsp_valid_ff || rsp_ch.ready;
   assign step        = req_valid_ff && advance;
   assign req_ch.ready = !req_valid_ff || advance;
   assign req_take    = req_ch.valid && req_ch.ready;

   assign req_valid_in = req_ch.ready ? req_ch.valid : req_valid_ff;
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.blink        = rsp_result_ff.blink;
   assign rsp_ch.second_blink = rsp_result_ff.second_blink;

   bdb_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bdb_classify #(
      .TIME_BITS (TIME_BITS)
   ) u_classify (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.sample_time_us <= req_ch.sample_time_us;
         req_item_ff.eye_closed     <= req_ch.eye_closed;
         req_item_ff.fixating       <= req_ch.fixating;
      end
      if (step) begin
         rsp_result_ff <= result;
      end
   end

endmodule

>>> design/bdb_checker.sv
module bdb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_blink,
   input logic rsp_second_blink
);

   // a stalled response keeps its flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blink) && $stable(rsp_second_blink))
      else $error("stalled response changed");

   // a fresh response follows a taken request through the input and output registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without matching request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_second_blink |-> rsp_blink)
      else $error("double blink without blink");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind blink_double_blink_classifier_top bdb_checker u_bdb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_blink        (rsp_ch.blink),
   .rsp_second_blink (rsp_ch.second_blink)
);

>>> tb/tb_blink_double_blink_classifier_top.sv
`timescale 1ns / 1ps

module tb_blink_double_blink_classifier_top;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int DIRECTED_ROWS = 24;
   localparam int STAMP_BITS    = bdb_pkg::SAMPLE_BITS;

   typedef struct {
      logic [STAMP_BITS-1:0] stamp;
      logic                  closed;
      logic                  gate;
      bit                    pinned;
      bdb_pkg::result_type   flags;
   } directed_row_type;

   typedef struct {
      bit                  pinned;
      bdb_pkg::result_type flags;
   } pinned_flags_type;

   logic clock;
   logic reset;

   bdb_req_if req_bus ();
   bdb_rsp_if rsp_bus ();
   bdb_csr_if csr_bus ();

   blink_double_blink_classifier_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // predictor state and thresholds
   bdb_pkg::cfg_type      pred_cfg;
   logic                  pred_prev_closed;
   bdb_pkg::count_type    pred_count;
   logic [STAMP_BITS-1:0] pred_close_t;
   logic [STAMP_BITS-1:0] pred_reopen_t;

   bdb_pkg::result_type expected_flags [$];
   pinned_flags_type    pinned_flags [$];

   int  cycle_count      = 0;
   int  mismatch_count   = 0;
   int  results_checked  = 0;
   int  samples_sent     = 0;
   int  blinks_seen      = 0;
   int  doubles_seen     = 0;
   int  settings_applied = 1;
   int  burst_left       = 0;
   int  receiver_hold_req = 0;

   // stimulus-side view of the eye
   logic                  eye_shut;
   logic [STAMP_BITS-1:0] stamp_now;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'd0,          1'b0, 1'b1, 1'b1, 2'b00},
      '{32'd100000,     1'b1, 1'b1, 1'b1, 2'b00},   // first closure, gap from zero
      '{32'd200000,     1'b0, 1'b1, 1'b1, 2'b10},
      '{32'd300000,     1'b1, 1'b1, 1'b1, 2'b00},
      '{32'd400000,     1'b0, 1'b1, 1'b1, 2'b11},   // second blink in a row
      '{32'd500000,     1'b1, 1'b0, 1'b1, 2'b00},   // gate low
      '{32'd500000,     1'b1, 1'b1, 1'b1, 2'b00},
      '{32'd550000,     1'b0, 1'b1, 1'b0, 2'b00},   // closure exactly at min
      '{32'd600000,     1'b1, 1'b1, 1'b1, 2'b00},   // gap exactly at min
      '{32'd850000,     1'b0, 1'b1, 1'b0, 2'b00},   // closure exactly at max
      '{32'd900001,     1'b1, 1'b1, 1'b1, 2'b00},
      '{32'd950002,     1'b0, 1'b1, 1'b0, 2'b00},
      '{32'd1450003,    1'b1, 1'b1, 1'b1, 2'b00},   // gap just past max
      '{32'd1700002,    1'b0, 1'b1, 1'b0, 2'b00},
      '{32'd1700003,    1'b0, 1'b1, 1'b1, 2'b00},   // no edge
      '{32'hFFFF_FFF0,  1'b1, 1'b1, 1'b1, 2'b00},
      '{32'h0001_0000,  1'b0, 1'b1, 1'b0, 2'b00},   // closure across the wrap
      '{32'h0000_1000,  1'b1, 1'b1, 1'b1, 2'b00},   // earlier stamp, huge gap
      '{32'h0000_0FFF,  1'b0, 1'b1, 1'b0, 2'b00},   // earlier stamp, huge closure
      '{32'hFFFF_FFFF,  1'b0, 1'b0, 1'b1, 2'b00},
      '{32'd0,          1'b1, 1'b0, 1'b1, 2'b00},
      '{32'hFFFF_FFFF,  1'b1, 1'b0, 1'b1, 2'b00},
      '{32'h0000_2000,  1'b1, 1'b1, 1'b1, 2'b00},   // gap below min
      '{32'd68192,      1'b0, 1'b1, 1'b0, 2'b00}
   };

   always #5 clock = ~clock;

   function automatic bdb_pkg::result_type classify_sample(bdb_pkg::item_type s);
      bdb_pkg::result_type   r;
      logic [STAMP_BITS-1:0] span;
      r = '0;
      if (s.fixating) begin
         if (s.eye_closed != pred_prev_closed) begin
            if (s.eye_closed) begin
               pred_close_t = s.sample_time_us;
               span = s.sample_time_us - pred_reopen_t;
               if (span < pred_cfg.min_gap_us || span > pred_cfg.max_gap_us)
                  pred_count = '0;
            end else begin
               pred_reopen_t = s.sample_time_us;
               span = s.sample_time_us - pred_close_t;
               if (span > pred_cfg.min_blink_us && span < pred_cfg.max_blink_us) begin
                  pred_count = pred_count + 1'b1;
                  r.blink = 1'b1;
               end else begin
                  pred_count = '0;
               end
            end
         end
         if (r.blink && pred_count == bdb_pkg::DOUBLE_COUNT) begin
            r.second_blink = 1'b1;
            pred_count = '0;
         end
         pred_prev_closed = s.eye_closed;
      end
      return r;
   endfunction

   // interval near the window edges, inside it, or anywhere up to just past twice the upper edge
   function automatic logic [STAMP_BITS-1:0] pick_interval(logic [STAMP_BITS-1:0] lo,
                                                           logic [STAMP_BITS-1:0] hi);
      case ($urandom_range(0, 4))
         0: return lo + $urandom_range(0, 2) - 1;
         1: return hi + $urandom_range(0, 2) - 1;
         2, 3: return $urandom_range(hi, lo);
         default: return $urandom_range(0, 2 * hi + 16);
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_flags.size());
         $display("tb_blink_double_blink_classifier_top failed");
         $finish;
      end
   end

   // monitor: responses first, a request accepted now cannot answer at this edge
   always @(posedge clock) begin
      bdb_pkg::item_type   s;
      bdb_pkg::result_type want;
      pinned_flags_type    plan;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (rsp_bus.blink) blinks_seen++;
            if (rsp_bus.second_blink) doubles_seen++;
            if (expected_flags.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response %0d: blink %0b double %0b", results_checked,
                           rsp_bus.blink, rsp_bus.second_blink);
            end else begin
               want = expected_flags.pop_front();
               if (want.blink !== rsp_bus.blink || want.second_blink !== rsp_bus.second_blink)
               begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch at response %0d: expected blink %0b double %0b,",
                               " got blink %0b double %0b"},
                              results_checked, want.blink, want.second_blink,
                              rsp_bus.blink, rsp_bus.second_blink);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            s.sample_time_us = req_bus.sample_time_us;
            s.eye_closed     = req_bus.eye_closed;
            s.fixating       = req_bus.fixating;
            want = classify_sample(s);
            plan = pinned_flags.pop_front();
            expected_flags.push_back(plan.pinned ? plan.flags : want);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               bdb_pkg::CSR_MIN_BLINK_US: pred_cfg.min_blink_us = csr_bus.data;
               bdb_pkg::CSR_MAX_BLINK_US: pred_cfg.max_blink_us = csr_bus.data;
               bdb_pkg::CSR_MIN_GAP_US:   pred_cfg.min_gap_us   = csr_bus.data;
               bdb_pkg::CSR_MAX_GAP_US:   pred_cfg.max_gap_us   = csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   // response side: stall patterns, plus a long hold-off on request
   initial begin
      int mode;
      int len;
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         len  = $urandom_range(8, 60);
         repeat (len) begin
            @(negedge clock);
            if (receiver_hold_req != 0) begin
               hold_left = receiver_hold_req;
               receiver_hold_req = 0;
            end
            if (hold_left != 0) begin
               hold_left--;
               rsp_bus.ready = 1'b0;
            end else begin
               case (mode)
                  0: rsp_bus.ready = 1'b1;
                  1: rsp_bus.ready = ($urandom_range(0, 3) != 0);
                  2: rsp_bus.ready = ($urandom_range(0, 1) == 1);
                  default: rsp_bus.ready = ($urandom_range(0, 9) == 0);
               endcase
            end
         end
      end
   end

   task automatic offer_sample(bdb_pkg::item_type s, bit pinned, bdb_pkg::result_type flags);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      pinned_flags.push_back('{pinned, flags});
      @(negedge clock);
      req_bus.sample_time_us = s.sample_time_us;
      req_bus.eye_closed     = s.eye_closed;
      req_bus.fixating       = s.fixating;
      req_bus.valid          = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_bus.valid = 1'b0;
      @(posedge clock);
      while (expected_flags.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(bdb_pkg::csr_index_type idx, bdb_pkg::cfg_word_type value);
      @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic apply_settings(bdb_pkg::cfg_word_type min_blink,
                                 bdb_pkg::cfg_word_type max_blink,
                                 bdb_pkg::cfg_word_type min_gap,
                                 bdb_pkg::cfg_word_type max_gap);
      wait_quiet();
      write_csr(bdb_pkg::CSR_MIN_BLINK_US, min_blink);
      write_csr(bdb_pkg::CSR_MAX_BLINK_US, max_blink);
      write_csr(bdb_pkg::CSR_MIN_GAP_US, min_gap);
      write_csr(bdb_pkg::CSR_MAX_GAP_US, max_gap);
      settings_applied++;
   endtask

   task automatic random_phase(int count, bit with_hold, bit with_pause);
      bdb_pkg::item_type s;
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == count / 2)
            receiver_hold_req = 80;
         if (with_pause && n == count / 2)
            wait_quiet();
         if ($urandom_range(0, 9) == 0) begin
            // noise: anything at all
            s.sample_time_us = $urandom;
            s.eye_closed     = ($urandom_range(0, 1) == 1);
            s.fixating       = ($urandom_range(0, 1) == 1);
            stamp_now = s.sample_time_us;
         end else if ($urandom_range(0, 3) == 0) begin
            // repeat of the current eye state, no edge
            s.sample_time_us = stamp_now + $urandom_range(0, 1000);
            s.eye_closed     = eye_shut;
            s.fixating       = ($urandom_range(0, 9) != 0);
         end else begin
            if (eye_shut)
               stamp_now = stamp_now + pick_interval(STAMP_BITS'(pred_cfg.min_blink_us),
                                                     STAMP_BITS'(pred_cfg.max_blink_us));
            else
               stamp_now = stamp_now + pick_interval(STAMP_BITS'(pred_cfg.min_gap_us),
                                                     STAMP_BITS'(pred_cfg.max_gap_us));
            s.sample_time_us = stamp_now;
            s.eye_closed     = !eye_shut;
            s.fixating       = ($urandom_range(0, 19) != 0);
         end
         if (s.fixating) eye_shut = s.eye_closed;
         offer_sample(s, 1'b0, '0);
      end
   endtask

   initial begin
      bdb_pkg::item_type     s;
      bdb_pkg::cfg_word_type lo_b;
      bdb_pkg::cfg_word_type lo_g;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.sample_time_us = '0;
      req_bus.eye_closed = 1'b0;
      req_bus.fixating = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = bdb_pkg::CSR_MIN_BLINK_US;
      csr_bus.data = '0;
      pred_cfg.min_blink_us = bdb_pkg::MIN_BLINK_US_RESET;
      pred_cfg.max_blink_us = bdb_pkg::MAX_BLINK_US_RESET;
      pred_cfg.min_gap_us   = bdb_pkg::MIN_GAP_US_RESET;
      pred_cfg.max_gap_us   = bdb_pkg::MAX_GAP_US_RESET;
      pred_prev_closed = 1'b0;
      pred_count = '0;
      pred_close_t = '0;
      pred_reopen_t = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         s.sample_time_us = directed_rows[i].stamp;
         s.eye_closed     = directed_rows[i].closed;
         s.fixating       = directed_rows[i].gate;
         offer_sample(s, directed_rows[i].pinned, directed_rows[i].flags);
      end
      eye_shut  = 1'b0;
      stamp_now = 32'd68192;
      random_phase(250, 1'b0, 1'b0);

      // widest windows, then junk writes to unused indices
      apply_settings('0, '1, '0, '1);
      for (int k = bdb_pkg::CSR_MAX_GAP_US + 1; k < 2 ** bdb_pkg::CSR_INDEX_BITS; k++)
         write_csr(bdb_pkg::csr_index_type'(k), bdb_pkg::cfg_word_type'($urandom));
      random_phase(250, 1'b0, 1'b0);

      // empty windows
      apply_settings('0, '0, '1, '0);
      random_phase(200, 1'b0, 1'b0);

      lo_b = bdb_pkg::cfg_word_type'($urandom_range(0, 200));
      lo_g = bdb_pkg::cfg_word_type'($urandom_range(0, 200));
      apply_settings(lo_b, bdb_pkg::cfg_word_type'(lo_b + $urandom_range(0, 400)),
                     lo_g, bdb_pkg::cfg_word_type'(lo_g + $urandom_range(0, 400)));
      random_phase(250, 1'b1, 1'b0);

      apply_settings(bdb_pkg::cfg_word_type'($urandom), bdb_pkg::cfg_word_type'($urandom),
                     bdb_pkg::cfg_word_type'($urandom), bdb_pkg::cfg_word_type'($urandom));
      random_phase(250, 1'b0, 1'b1);

      // defaults again, running through the timestamp wrap
      apply_settings(bdb_pkg::MIN_BLINK_US_RESET, bdb_pkg::MAX_BLINK_US_RESET,
                     bdb_pkg::MIN_GAP_US_RESET, bdb_pkg::MAX_GAP_US_RESET);
      stamp_now = 32'hFFF0_0000;
      random_phase(330, 1'b1, 1'b0);

      wait_quiet();
      $display("%0d samples sent, %0d checked over %0d threshold settings", samples_sent,
               results_checked, settings_applied);
      $display("%0d blinks and %0d double blinks observed, %0d mismatches", blinks_seen,
               doubles_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_blink_double_blink_classifier_top passed");
      end else begin
         $display("tb_blink_double_blink_classifier_top failed");
      end
      $finish;
   end

endmodule

>>> sim.f
design/bdb_pkg.sv
design/bdb_ifs.sv
design/bdb_csr.sv
design/bdb_classify.sv
design/blink_double_blink_classifier_top.sv
design/bdb_checker.sv
tb/tb_blink_double_blink_classifier_top.sv
